>>> design/majority_base_consensus_macros.svh
// Assertion helpers shared by the consensus block.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef MAJORITY_BASE_CONSENSUS_MACROS_SVH
`define MAJORITY_BASE_CONSENSUS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MBC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MBC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/mbc_pkg.sv
`timescale 1ns / 1ps

package mbc_pkg;

    localparam int POSITIONS = 4;
    localparam int BASES     = 4;
    localparam int CODE_W    = 4;
    localparam int BASE_W    = 2;
    localparam int TALLY_W   = 8;
    localparam int TOTAL_W   = TALLY_W + 2;

    localparam logic [TALLY_W-1:0] TALLY_MAX         = 8'd255;
    localparam logic [7:0]         MIN_SUPPORT_RESET = 8'd3;

    typedef struct packed {
        logic signed [CODE_W-1:0] base_p0;
        logic signed [CODE_W-1:0] base_p1;
        logic signed [CODE_W-1:0] base_p2;
        logic signed [CODE_W-1:0] base_p3;
        logic                     final_molecule;
    } in_item_t;

    typedef struct packed {
        logic              consensus_ok;
        logic [BASE_W-1:0] cons_p0;
        logic [BASE_W-1:0] cons_p1;
        logic [BASE_W-1:0] cons_p2;
        logic [BASE_W-1:0] cons_p3;
    } out_item_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic count_en;
        logic eval_en;
    } dp_cmd_t;

endpackage

>>> design/mbc_datapath.sv
`timescale 1ns / 1ps

module mbc_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  mbc_pkg::dp_cmd_t   cmd,
    input  mbc_pkg::in_item_t  in_data,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data,
    output mbc_pkg::out_item_t out_data
);
    import mbc_pkg::*;

    logic [TALLY_W-1:0]        tally_reg [POSITIONS][BASES];
    logic [7:0]                min_support_reg;
    out_item_t                 result_reg;
    out_item_t                 result_next;

    logic signed [CODE_W-1:0]  codes [POSITIONS];
    logic [TOTAL_W-1:0]        total_c [POSITIONS];
    logic [TALLY_W-1:0]        best_c [POSITIONS];
    logic [BASE_W-1:0]         pick_c [POSITIONS];
    logic [POSITIONS-1:0]      found_c;
    logic [POSITIONS-1:0]      pos_ok;
    logic                      all_ok;

    assign codes[0] = in_data.base_p0;
    assign codes[1] = in_data.base_p1;
    assign codes[2] = in_data.base_p2;
    assign codes[3] = in_data.base_p3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_support_reg <= MIN_SUPPORT_RESET;
            for (int p = 0; p < POSITIONS; p++)
            begin
                for (int b = 0; b < BASES; b++)
                begin
                    tally_reg[p][b] <= '0;
                end
            end
        end
        else
        begin
            if (cfg_wr_en)
            begin
                min_support_reg <= cfg_wr_data;
            end
            for (int p = 0; p < POSITIONS; p++)
            begin
                for (int b = 0; b < BASES; b++)
                begin
                    if (cmd.eval_en)
                    begin
                        tally_reg[p][b] <= '0;
                    end
                    // Only codes 0 to 3 count; negative and larger codes have upper bits set.
                    else if (cmd.count_en && codes[p][CODE_W-1:BASE_W] == '0 &&
                             codes[p][BASE_W-1:0] == BASE_W'(b) &&
                             tally_reg[p][b] != TALLY_MAX)
                    begin
                        tally_reg[p][b] <= tally_reg[p][b] + 1'b1;
                    end
                end
            end
        end
    end

    // Per position: highest eligible tally, lower code wins a tie.
    always_comb
    begin
        for (int p = 0; p < POSITIONS; p++)
        begin
            total_c[p] = '0;
            best_c[p]  = '0;
            pick_c[p]  = '0;
            found_c[p] = 1'b0;
            for (int b = 0; b < BASES; b++)
            begin
                total_c[p] = total_c[p] + {2'b00, tally_reg[p][b]};
                if (tally_reg[p][b] > min_support_reg && tally_reg[p][b] > best_c[p])
                begin
                    best_c[p]  = tally_reg[p][b];
                    pick_c[p]  = BASE_W'(b);
                    found_c[p] = 1'b1;
                end
            end
            pos_ok[p] = found_c[p] &&
                        ({2'b00, best_c[p]} > {1'b0, total_c[p][TOTAL_W-1:1]});
        end
    end

    assign all_ok = &pos_ok;

    always_comb
    begin
        result_next.consensus_ok = all_ok;
        result_next.cons_p0      = all_ok ? pick_c[0] : '0;
        result_next.cons_p1      = all_ok ? pick_c[1] : '0;
        result_next.cons_p2      = all_ok ? pick_c[2] : '0;
        result_next.cons_p3      = all_ok ? pick_c[3] : '0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_en)
        begin
            result_reg <= result_next;
        end
    end

    assign out_data = result_reg;

endmodule

>>> design/mbc_ctrl.sv
`timescale 1ns / 1ps

module mbc_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_final,
    output logic             in_stall,
    output logic             out_valid,
    input  logic             out_stall,
    output mbc_pkg::dp_cmd_t cmd
);
    import mbc_pkg::*;

    `include "majority_base_consensus_macros.svh"

    typedef enum logic {
        ACCUM,
        EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   load;

    assign in_stall     = (state_reg == EVAL);
    assign cmd.count_en = in_valid && !in_stall;
    // The result register is free when empty or when its transfer completes now.
    assign load         = (state_reg == EVAL) && (!out_valid_reg || !out_stall);
    assign cmd.eval_en  = load;
    assign out_valid    = out_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && out_stall;
        unique case (state_reg)
            ACCUM:
            begin
                if (cmd.count_en && in_final)
                begin
                    state_next = EVAL;
                end
            end
            EVAL:
            begin
                if (load)
                begin
                    state_next     = ACCUM;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ACCUM;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `MBC_ASSERT_NEXT(a_final_goes_eval, cmd.count_en && in_final, state_reg == EVAL,
        "accepted final item did not start evaluation")
    `MBC_ASSERT_NEXT(a_load_shows_result, cmd.eval_en, out_valid && state_reg == ACCUM,
        "evaluation did not present a result")
    `MBC_ASSERT_SAME(a_no_count_in_eval, state_reg == EVAL, !cmd.count_en && !in_stall == 1'b0,
        "item counted during evaluation")

endmodule

>>> design/majority_base_consensus.sv
`timescale 1ns / 1ps
// Channel   Signals                        Transfer when
// input     in_valid, in_stall, in_data    in_valid && !in_stall
// output    out_valid, out_stall, out_data out_valid && !out_stall
// config    cfg_wr_en, cfg_wr_data         cfg_wr_en
//
// A counted item updates the tallies at its transfer.
// After an item marked final the input stalls in an evaluation state that
// evaluates the tallies into the result register and clears them; this
// state waits while the previous result is still stalled at the output.
// Reset clears all tallies, sets min_support to 3 and empties the output.

module majority_base_consensus (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  mbc_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output mbc_pkg::out_item_t out_data,
    input  logic               cfg_wr_en,
    input  logic [7:0]         cfg_wr_data
);
    import mbc_pkg::*;

    dp_cmd_t cmd;

    mbc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_final  (in_data.final_molecule),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd)
    );

    mbc_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_data     (in_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .out_data    (out_data)
    );

endmodule

>>> sim/majority_base_consensus_tb.sv
`timescale 1ns / 1ps

module majority_base_consensus_tb;
    import mbc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 7;
    localparam int MAX_WAIT      = 13;
    localparam int SETTLE_CYCLES = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int PHASE_ITEMS   = 65;
    localparam int PHASES        = 8;
    localparam int LONG_PHASE    = 6;
    localparam int LONG_RUN      = 300;
    localparam int MAX_REPORTS   = 10;
    localparam int ABSENT_CODE   = -1;

    // Directed table columns: four base codes, final flag, typed flag, then the
    // typed result (ok and four consensus bases).
    localparam int DIR_ROWS  = 22;
    localparam int DIR_COLS  = 11;
    localparam int COL_FINAL = 4;
    localparam int COL_TYPED = 5;
    localparam int COL_OK    = 6;
    localparam int COL_CONS  = 7;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_item_t   in_data;
    logic       out_valid;
    logic       out_stall;
    out_item_t  out_data;
    logic       cfg_wr_en;
    logic [7:0] cfg_wr_data;

    logic [TALLY_W-1:0] base_count [POSITIONS][BASES];
    logic [7:0]         support_level;
    out_item_t          consensus_q [$];
    int                 mismatches  = 0;
    int unsigned        cycle_count = 0;
    int                 send_calm   = 0;

    int dir_tbl [DIR_ROWS][DIR_COLS] = '{
        '{ABSENT_CODE, ABSENT_CODE, ABSENT_CODE, ABSENT_CODE, 1, 1, 0, 0, 0, 0, 0},
        '{0, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 2, 3, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 2, 3, 1, 1, 1, 0, 1, 2, 3},
        '{4, 5, 6, 7, 0, 0, 0, 0, 0, 0, 0},
        '{-8, -5, -2, ABSENT_CODE, 0, 0, 0, 0, 0, 0, 0},
        '{3, 3, 3, 3, 1, 1, 0, 0, 0, 0, 0},
        '{2, 2, 2, 2, 0, 0, 0, 0, 0, 0, 0},
        '{2, 2, 2, 2, 0, 0, 0, 0, 0, 0, 0},
        '{2, 2, 2, 2, 0, 0, 0, 0, 0, 0, 0},
        '{2, 2, 2, 2, 0, 0, 0, 0, 0, 0, 0},
        '{1, 7, -8, 6, 1, 0, 0, 0, 0, 0, 0},
        '{1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{1, 0, 1, 0, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 0, 1, 0, 0, 0, 0, 0, 0, 0},
        '{0, 1, 0, 1, 1, 0, 0, 0, 0, 0, 0}
    };

    majority_base_consensus i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_data    (out_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    initial clk = 1'b0;
    always #(CLK_HALF) clk = ~clk;

    function automatic void clear_counts();
        for (int p = 0; p < POSITIONS; p++)
            for (int b = 0; b < BASES; b++)
                base_count[p][b] = '0;
    endfunction

    function automatic void queue_result(input out_item_t r);
        consensus_q.insert(consensus_q.size(), r);
    endfunction

    // Counts one molecule and, on the final one, forms the consensus and
    // clears the counts. Returns 1 when a result is produced.
    function automatic bit tally_molecule(input in_item_t item, output out_item_t res);
        logic signed [CODE_W-1:0] codes [POSITIONS];
        logic [BASE_W-1:0]        picks [POSITIONS];
        int                       total;
        int                       best;
        int                       pick;
        bit                       ok;
        res = '0;
        codes[0] = item.base_p0;
        codes[1] = item.base_p1;
        codes[2] = item.base_p2;
        codes[3] = item.base_p3;
        for (int p = 0; p < POSITIONS; p++)
            if (codes[p] >= 0 && codes[p] < BASES
                    && base_count[p][codes[p][BASE_W-1:0]] != TALLY_MAX)
                base_count[p][codes[p][BASE_W-1:0]] += 1'b1;
        if (!item.final_molecule)
            return 1'b0;
        ok = 1'b1;
        for (int p = 0; p < POSITIONS; p++)
        begin
            total = 0;
            best  = 0;
            pick  = -1;
            for (int b = 0; b < BASES; b++)
            begin
                total += base_count[p][b];
                // Strictly greater keeps the lower base code on a tie.
                if (base_count[p][b] > support_level && base_count[p][b] > best)
                begin
                    best = base_count[p][b];
                    pick = b;
                end
            end
            if (pick < 0 || best <= total / 2)
            begin
                ok       = 1'b0;
                picks[p] = '0;
            end
            else
                picks[p] = BASE_W'(pick);
        end
        if (ok)
        begin
            res.consensus_ok = 1'b1;
            res.cons_p0      = picks[0];
            res.cons_p1      = picks[1];
            res.cons_p2      = picks[2];
            res.cons_p3      = picks[3];
        end
        clear_counts();
        return 1'b1;
    endfunction

    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic logic signed [CODE_W-1:0] draw_code(input logic [BASE_W-1:0] dom,
                                                          input int focus);
        int pick;
        if ($urandom_range(0, 99) < focus)
            return {2'b00, dom};
        pick = $urandom_range(0, 9);
        if (pick < 5)
            return CODE_W'($urandom_range(0, BASES - 1));
        if (pick < 7)
            return CODE_W'(ABSENT_CODE);
        return CODE_W'($urandom_range(0, 15));
    endfunction

    function automatic string show(input out_item_t v);
        return $sformatf("ok=%0b cons=%0d,%0d,%0d,%0d",
                         v.consensus_ok, v.cons_p0, v.cons_p1, v.cons_p2, v.cons_p3);
    endfunction

    // Called and returns at a falling edge. Valid is only lowered when a gap
    // is drawn, so back-to-back transfers keep it high.
    task automatic send_item(input in_item_t item, input bit typed, input out_item_t want);
        int        gap;
        out_item_t res;
        gap = draw_wait(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (tally_molecule(item, res))
            queue_result(typed ? want : res);
        @(negedge clk);
    endtask

    task automatic send_run(input int len, input int focus);
        logic [BASE_W-1:0] dom [POSITIONS];
        in_item_t          item;
        for (int p = 0; p < POSITIONS; p++)
            dom[p] = BASE_W'($urandom_range(0, BASES - 1));
        for (int i = 0; i < len; i++)
        begin
            item.base_p0        = draw_code(dom[0], focus);
            item.base_p1        = draw_code(dom[1], focus);
            item.base_p2        = draw_code(dom[2], focus);
            item.base_p3        = draw_code(dom[3], focus);
            item.final_molecule = (i == len - 1);
            send_item(item, 1'b0, '0);
        end
    endtask

    // A final item keeps the block busy in evaluation after its transfer, so
    // wait until the last result is taken and settle before touching the register.
    task automatic drain();
        in_valid <= 1'b0;
        while (consensus_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_support(input logic [7:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge clk);
        cfg_wr_en     <= 1'b0;
        support_level  = value;
    endtask

    initial
    begin
        in_item_t  item;
        out_item_t want;
        int        sent;
        int        run_len;
        int        focus;
        int        support_plan [PHASES];
        in_valid      = 1'b0;
        in_data       = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        rst_n         = 1'b0;
        support_level = MIN_SUPPORT_RESET;
        clear_counts();
        support_plan  = '{0, 1, 255, 2, 0, 3, 254, 0};
        support_plan[4] = $urandom_range(4, 253);
        support_plan[7] = $urandom_range(4, 253);
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int r = 0; r < DIR_ROWS; r++)
        begin
            item.base_p0        = CODE_W'(dir_tbl[r][0]);
            item.base_p1        = CODE_W'(dir_tbl[r][1]);
            item.base_p2        = CODE_W'(dir_tbl[r][2]);
            item.base_p3        = CODE_W'(dir_tbl[r][3]);
            item.final_molecule = dir_tbl[r][COL_FINAL][0];
            want.consensus_ok   = dir_tbl[r][COL_OK][0];
            want.cons_p0        = BASE_W'(dir_tbl[r][COL_CONS]);
            want.cons_p1        = BASE_W'(dir_tbl[r][COL_CONS + 1]);
            want.cons_p2        = BASE_W'(dir_tbl[r][COL_CONS + 2]);
            want.cons_p3        = BASE_W'(dir_tbl[r][COL_CONS + 3]);
            send_item(item, dir_tbl[r][COL_TYPED] != 0, want);
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            drain();
            write_support(8'(support_plan[ph]));
            sent = 0;
            // One long run pushes every dominant count into saturation.
            if (ph == LONG_PHASE)
            begin
                send_run(LONG_RUN, 92);
                sent = LONG_RUN;
            end
            while (sent < PHASE_ITEMS)
            begin
                run_len = ($urandom_range(0, 9) == 0) ? $urandom_range(11, 24)
                                                      : $urandom_range(1, 10);
                focus   = ($urandom_range(0, 6) == 0) ? 0 : $urandom_range(50, 95);
                send_run(run_len, focus);
                sent += run_len;
            end
        end

        drain();
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        int hold;
        int calm;
        calm      = 0;
        out_stall = 1'b0;
        wait (rst_n);
        @(negedge clk);
        forever
        begin
            hold = draw_wait(calm);
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
            end
            out_stall <= 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (consensus_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: %s", show(out_data));
            end
            else
            begin
                want = consensus_q.pop_front();
                if (out_data.consensus_ok !== want.consensus_ok
                        || out_data.cons_p0 !== want.cons_p0
                        || out_data.cons_p1 !== want.cons_p1
                        || out_data.cons_p2 !== want.cons_p2
                        || out_data.cons_p3 !== want.cons_p3)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("mismatch: expected %s, got %s", show(want), show(out_data));
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule

>>> filelist.f
+incdir+design
design/mbc_pkg.sv
design/mbc_datapath.sv
design/mbc_ctrl.sv
design/majority_base_consensus.sv
sim/majority_base_consensus_tb.sv
